/* rtl/core/priority_ready_queue_with_purge_defines.svh */
// ----------------------------------------------------------------------------
// priority_ready_queue_with_purge_defines
// assertion macros shared by the ready queue modules
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_WITH_PURGE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_WITH_PURGE_DEFINES_SVH

// same-cycle implication
`define PRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// shared constants and types of the ready queue
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TREE_LEAVES = 2 ** IDX_W;

	localparam int PID_W   = 16;
	localparam int PRIO_W  = 8;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 5;

	localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
	localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;    // capture the accepted item
		logic search;  // register the selected slot
		logic commit;  // update the queue and load the result
	} prq_cmd_t;

endpackage

/* rtl/core/priority_ready_queue_with_purge.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_with_purge
// Bounded ready queue of (pid, priority) entries with enqueue, dequeue
// (head in fifo mode, else lowest priority value with the oldest winning a
// tie) and purge of the oldest matching pid; every operation returns one
// result with status, removed entry, entry total and empty flag. The
// search state registers the slot chosen by the minimum tree or the pid
// match encoder; the commit state applies the append or compacting shift
// and loads the result register. A new item is taken in the commit state,
// while the pending result is drained. The user must write fifo_mode through
// cfg_wr_en/cfg_wr_data while the queue is idle; it is not enforced.
// ----------------------------------------------------------------------------
module priority_ready_queue_with_purge import prq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [PID_W-1:0]   item_pid,
	input  logic [PRIO_W-1:0]  item_priority,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [PID_W-1:0]   out_pid,
	output logic [PRIO_W-1:0]  out_priority,
	output logic [TOTAL_W-1:0] entry_total,
	output logic               is_empty
);

	prq_cmd_t cmd;

	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	prq_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.item_pid      (item_pid),
		.item_priority (item_priority),
		.status        (status),
		.out_pid       (out_pid),
		.out_priority  (out_priority),
		.entry_total   (entry_total),
		.is_empty      (is_empty)
	);

endmodule

/* rtl/core/prq_search.sv */
// ----------------------------------------------------------------------------
// prq_search
// minimum-priority tree and first-pid-match encoder over the held slots
// ----------------------------------------------------------------------------
module prq_search import prq_pkg::*; (
	input  logic [PID_W-1:0]  slot_pid  [QUEUE_DEPTH],
	input  logic [PRIO_W-1:0] slot_prio [QUEUE_DEPTH],
	input  logic [CNT_W-1:0]  count,
	input  logic [PID_W-1:0]  key_pid,
	output logic [IDX_W-1:0]  min_idx,
	output logic [IDX_W-1:0]  match_idx,
	output logic              match_hit
);

	logic              node_ok   [2*TREE_LEAVES];
	logic [PRIO_W-1:0] node_prio [2*TREE_LEAVES];
	logic [IDX_W-1:0]  node_idx  [2*TREE_LEAVES];

	// heap-ordered tree, leaves at TREE_LEAVES + i; left (older) wins a tie
	always_comb begin
		for (int n = 0; n < 2*TREE_LEAVES; n++) begin
			node_ok[n]   = 1'b0;
			node_prio[n] = '0;
			node_idx[n]  = '0;
		end
		for (int i = 0; i < TREE_LEAVES; i++) begin
			if (i < QUEUE_DEPTH) begin
				node_ok[TREE_LEAVES+i]   = (CNT_W'(i) < count);
				node_prio[TREE_LEAVES+i] = slot_prio[i];
			end
			node_idx[TREE_LEAVES+i] = IDX_W'(i);
		end
		for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
			if (node_ok[2*n+1] && (!node_ok[2*n] || node_prio[2*n+1] < node_prio[2*n])) begin
				node_ok[n]   = 1'b1;
				node_prio[n] = node_prio[2*n+1];
				node_idx[n]  = node_idx[2*n+1];
			end else begin
				node_ok[n]   = node_ok[2*n];
				node_prio[n] = node_prio[2*n];
				node_idx[n]  = node_idx[2*n];
			end
		end
	end

	assign min_idx = (TREE_LEAVES > 1) ? node_idx[1] : '0;

	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (CNT_W'(i) < count && slot_pid[i] == key_pid) begin
				match_hit = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

endmodule

/* rtl/core/prq_dpath.sv */
// ----------------------------------------------------------------------------
// prq_dpath
// slot registers, entry count, mode register and result registers
// ----------------------------------------------------------------------------
module prq_dpath import prq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  prq_cmd_t           cmd,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic [OP_W-1:0]    opcode,
	input  logic [PID_W-1:0]   item_pid,
	input  logic [PRIO_W-1:0]  item_priority,
	output logic [STAT_W-1:0]  status,
	output logic [PID_W-1:0]   out_pid,
	output logic [PRIO_W-1:0]  out_priority,
	output logic [TOTAL_W-1:0] entry_total,
	output logic               is_empty
);

	`include "priority_ready_queue_with_purge_defines.svh"

	logic [PID_W-1:0]   slot_pid_q  [QUEUE_DEPTH];
	logic [PRIO_W-1:0]  slot_prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic               fifo_mode_q;
	logic [OP_W-1:0]    op_q;
	logic [PID_W-1:0]   pid_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [IDX_W-1:0]   sel_s1;
	logic               hit_s1;
	logic [STAT_W-1:0]  status_q;
	logic [PID_W-1:0]   rpid_q;
	logic [PRIO_W-1:0]  rprio_q;
	logic [TOTAL_W-1:0] total_q;
	logic               empty_q;

	logic [IDX_W-1:0]   min_idx;
	logic [IDX_W-1:0]   match_idx;
	logic               match_hit;
	logic               full;
	logic               do_enq;
	logic               do_remove;
	logic [CNT_W-1:0]   count_nxt;
	logic [STAT_W-1:0]  status_nxt;

	prq_search u_search (
		.slot_pid  (slot_pid_q),
		.slot_prio (slot_prio_q),
		.count     (count_q),
		.key_pid   (pid_q),
		.min_idx   (min_idx),
		.match_idx (match_idx),
		.match_hit (match_hit)
	);

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_enq    = (op_q == OP_ENQ) && !full;
	assign do_remove = (op_q == OP_DEQ || op_q == OP_PURGE) && hit_s1;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		case (op_q)
			OP_ENQ: begin
				if (full) status_nxt = ST_FULL;
				else      count_nxt  = count_q + CNT_W'(1);
			end
			OP_DEQ, OP_PURGE: begin
				if (hit_s1) count_nxt  = count_q - CNT_W'(1);
				else        status_nxt = ST_MISS;
			end
			default: begin
				count_nxt  = count_q;
				status_nxt = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fifo_mode_q <= 1'b0;
		end else begin
			if (cfg_wr_en) fifo_mode_q <= cfg_wr_data;
			if (cmd.commit) count_q <= count_nxt;
		end
	end

	// item capture, slot selection and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			pid_q  <= item_pid;
			prio_q <= item_priority;
		end
		if (cmd.search) begin
			if (op_q == OP_DEQ) begin
				sel_s1 <= fifo_mode_q ? '0 : min_idx;
				hit_s1 <= (count_q != '0);
			end else begin
				sel_s1 <= match_idx;
				hit_s1 <= match_hit;
			end
		end
		if (cmd.commit) begin
			status_q <= status_nxt;
			rpid_q   <= do_remove ? slot_pid_q[sel_s1]  : '0;
			rprio_q  <= do_remove ? slot_prio_q[sel_s1] : '0;
			total_q  <= TOTAL_W'(count_nxt);
			empty_q  <= (count_nxt == '0);
		end
	end

	// append at the tail, or close the gap left by a removal
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (do_enq) begin
				slot_pid_q[count_q[IDX_W-1:0]]  <= pid_q;
				slot_prio_q[count_q[IDX_W-1:0]] <= prio_q;
			end else if (do_remove) begin
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					if (IDX_W'(i) >= sel_s1) begin
						slot_pid_q[i]  <= slot_pid_q[i+1];
						slot_prio_q[i] <= slot_prio_q[i+1];
					end
				end
			end
		end
	end

	assign status       = status_q;
	assign out_pid      = rpid_q;
	assign out_priority = rprio_q;
	assign entry_total  = total_q;
	assign is_empty     = empty_q;

	`PRQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH),
		"entry count above queue depth")
	`PRQ_ASSERT_NOW(a_remove_in_range, clk, arst_n, cmd.commit && do_remove,
		CNT_W'(sel_s1) < count_q, "removal outside held entries")

endmodule

/* rtl/core/prq_ctrl.sv */
// ----------------------------------------------------------------------------
// prq_ctrl
// sequencer for accept, slot search and commit, and result valid
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output prq_cmd_t cmd
);

	`include "priority_ready_queue_with_purge_defines.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_go;
	logic   load;

	// result slot is free or being drained this cycle
	assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
	assign in_stall  = !((state_q == S_IDLE) || commit_go);
	assign load      = in_valid && !in_stall;

	assign cmd.load   = load;
	assign cmd.search = (state_q == S_SEARCH);
	assign cmd.commit = commit_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (commit_go)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (load) state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_go) state_q <= load ? S_SEARCH : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`PRQ_ASSERT_NEXT(a_accept_to_search, clk, arst_n, load, state_q == S_SEARCH,
		"accepted transfer did not start a search")
	`PRQ_ASSERT_NEXT(a_search_to_commit, clk, arst_n, state_q == S_SEARCH,
		state_q == S_COMMIT, "search did not move to commit")
	`PRQ_ASSERT_NEXT(a_hold_blocked_commit, clk, arst_n,
		state_q == S_COMMIT && out_valid_q && out_stall,
		state_q == S_COMMIT && out_valid_q, "pending result overwritten")

endmodule
